// ----- design/art_pkg.sv -----
package art_pkg;

  localparam int Capacity = 256;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);

  typedef enum logic [1:0] {
    REQ_SEARCH = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] src_type;
    logic [15:0] tgt_type;
    logic [15:0] tgt_class;
    logic [7:0]  kind_mask;
    logic [31:0] data_word0;
    logic [31:0] data_word1;
    logic [31:0] data_word2;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  found_kind;
    logic [31:0] found_word0;
    logic [31:0] found_word1;
    logic [31:0] found_word2;
    logic [8:0]  entry_count;
  } out_item_t;

  typedef struct packed {
    logic [47:0] key;
    logic [7:0]  kind;
    logic [95:0] words;
  } entry_t;

  // token that travels along the chain with the probe key
  typedef struct packed {
    logic        vld;
    logic        hit;
    logic [47:0] key;
    logic [7:0]  mask;
    logic [7:0]  kind;
    logic [95:0] words;
  } probe_t;

endpackage

// ----- design/art_cell.sv -----
module art_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  art_pkg::entry_t wr_entry,
  input  logic            active,
  input  art_pkg::probe_t probe_in,
  output art_pkg::probe_t probe_out
);
  import art_pkg::*;

  entry_t ent_r;
  probe_t probe_r, probe_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_r <= wr_entry;
    end
  end

  always_comb begin
    probe_nxt = probe_in;
    if (probe_in.vld && !probe_in.hit && active &&
        ent_r.key == probe_in.key && (ent_r.kind & probe_in.mask) != 8'd0) begin
      probe_nxt.hit   = 1'b1;
      probe_nxt.kind  = ent_r.kind;
      probe_nxt.words = ent_r.words;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.vld <= 1'b0;
    end else begin
      probe_r.vld <= probe_nxt.vld;
    end
    probe_r.hit   <= probe_nxt.hit;
    probe_r.key   <= probe_nxt.key;
    probe_r.mask  <= probe_nxt.mask;
    probe_r.kind  <= probe_nxt.kind;
    probe_r.words <= probe_nxt.words;
  end

  assign probe_out = probe_r;
endmodule

// ----- design/access_rule_table_unit.sv -----
// Search and insert send a probe through the cell chain, one cell per cycle; the result
//   is taken from the chain tail. Clear and unused codes answer the cycle after accept.
// Rate: clear and unused codes one per cycle unless the result stalls; one item in
//   flight, so the input is held off during a walk and while a stalled result waits.
// Reset: entry count and control cleared; cell contents undefined until written.
module access_rule_table_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  art_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output art_pkg::out_item_t  out_data
);
  import art_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } fsm_t;

  fsm_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  in_item_t req_r;
  out_item_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept, launch, res_free;

  probe_t chain [0:Capacity];
  logic [Capacity-1:0] wr_en;
  entry_t wr_entry;

  assign res_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !res_free;
  assign accept   = in_valid && !in_stall;
  assign launch   = accept && (in_data.req_type == REQ_SEARCH ||
                               in_data.req_type == REQ_INSERT);

  assign chain[0].vld   = launch;
  assign chain[0].hit   = 1'b0;
  assign chain[0].key   = {in_data.src_type, in_data.tgt_type, in_data.tgt_class};
  assign chain[0].mask  = in_data.kind_mask;
  assign chain[0].kind  = 8'd0;
  assign chain[0].words = 96'd0;

  assign wr_entry = '{key:   {req_r.src_type, req_r.tgt_type, req_r.tgt_class},
                      kind:  req_r.kind_mask,
                      words: {req_r.data_word0, req_r.data_word1, req_r.data_word2}};

  logic done, do_ins;
  probe_t tail;
  assign tail = chain[Capacity];
  assign done = (state_r == S_WALK) && tail.vld;
  assign do_ins = done && req_r.req_type == REQ_INSERT && !tail.hit &&
                  cnt_r < CntW'(Capacity);

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    assign wr_en[g] = do_ins && cnt_r == CntW'(g);
    art_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (wr_en[g]),
      .wr_entry (wr_entry),
      .active   (CntW'(g) < cnt_r),
      .probe_in (chain[g]),
      .probe_out(chain[g+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (launch) begin
            state_nxt = S_WALK;
          end else begin
            if (in_data.req_type == REQ_CLEAR) begin
              cnt_nxt = '0;
            end
            res_nxt = '0;
            res_nxt.status = ST_OK;
            res_nxt.entry_count = 9'(in_data.req_type == REQ_CLEAR ? '0 : cnt_r);
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_WALK: begin
        if (done) begin
          state_nxt = S_IDLE;
          res_nxt = '0;
          if (req_r.req_type == REQ_SEARCH) begin
            if (tail.hit) begin
              res_nxt.status      = ST_OK;
              res_nxt.found_kind  = tail.kind;
              res_nxt.found_word0 = tail.words[95:64];
              res_nxt.found_word1 = tail.words[63:32];
              res_nxt.found_word2 = tail.words[31:0];
            end else begin
              res_nxt.status = ST_NOT_FOUND;
            end
            res_nxt.entry_count = 9'(cnt_r);
          end else if (tail.hit) begin
            res_nxt.status = ST_DUPLICATE;
            res_nxt.entry_count = 9'(cnt_r);
          end else if (!do_ins) begin
            res_nxt.status = ST_FULL;
            res_nxt.entry_count = 9'(cnt_r);
          end else begin
            res_nxt.status = ST_OK;
            cnt_nxt = cnt_r + 1'b1;
            res_nxt.entry_count = 9'(cnt_nxt);
          end
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r <= res_nxt;
    if (accept) begin
      req_r <= in_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;
endmodule

// ----- design/art_checker.sv -----
module art_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input art_pkg::out_item_t out_data
);
  import art_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.entry_count <= 9'(Capacity))
    else $error("entry count beyond capacity");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.found_kind == 8'd0)
    else $error("found kind on failed request");

  a_hit_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found_kind != 8'd0 |-> out_data.status == ST_OK)
    else $error("found kind with bad status");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result waits");

endmodule

bind access_rule_table_unit art_checker u_art_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// ----- tb/access_rule_table_unit_tb.sv -----
module access_rule_table_unit_tb;
  import art_pkg::*;

  localparam int WatchLimit = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;

  access_rule_table_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // table shadow
  logic [47:0] rule_keys [Capacity];
  logic [7:0]  rule_kinds [Capacity];
  logic [95:0] rule_words [Capacity];
  int unsigned rule_count;

  out_item_t pending_results [$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned full_hits, dup_hits, found_hits;
  int unsigned idle_cycles;
  bit hold_long;

  // small key pool so searches and duplicates actually hit
  logic [47:0] key_pool [8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_item_t lookup_rule(input in_item_t req);
    out_item_t res;
    logic [47:0] key;
    int hit;
    res = '0;
    key = {req.src_type, req.tgt_type, req.tgt_class};
    hit = -1;
    if (req.req_type == REQ_SEARCH || req.req_type == REQ_INSERT) begin
      for (int i = 0; i < rule_count; i++) begin
        if (hit < 0 && rule_keys[i] == key && (rule_kinds[i] & req.kind_mask) != 8'd0) hit = i;
      end
    end
    case (req.req_type)
      REQ_SEARCH: begin
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.status = ST_OK;
          res.found_kind = rule_kinds[hit];
          {res.found_word0, res.found_word1, res.found_word2} = rule_words[hit];
        end
      end
      REQ_INSERT: begin
        if (hit >= 0) begin
          res.status = ST_DUPLICATE;
        end else if (rule_count >= Capacity) begin
          res.status = ST_FULL;
        end else begin
          res.status = ST_OK;
          rule_keys[rule_count] = key;
          rule_kinds[rule_count] = req.kind_mask;
          rule_words[rule_count] = {req.data_word0, req.data_word1, req.data_word2};
          rule_count++;
        end
      end
      REQ_CLEAR: begin
        res.status = ST_OK;
        rule_count = 0;
      end
      default: res.status = ST_OK;
    endcase
    res.entry_count = rule_count[8:0];
    return res;
  endfunction

  function automatic in_item_t rand_req(input int unsigned mode);
    in_item_t r;
    int unsigned p;
    r.data_word0 = $urandom;
    r.data_word1 = $urandom;
    r.data_word2 = $urandom;
    p = $urandom_range(0, 99);
    if (p < 4) r.kind_mask = 8'd0;
    else if (p < 60) r.kind_mask = 8'd1 << $urandom_range(0, 7);
    else r.kind_mask = 8'($urandom);
    if ($urandom_range(0, 9) < 8) begin
      {r.src_type, r.tgt_type, r.tgt_class} = key_pool[$urandom_range(0, 7)];
    end else begin
      r.src_type = 16'($urandom);
      r.tgt_type = 16'($urandom);
      r.tgt_class = 16'($urandom);
    end
    p = $urandom_range(0, 999);
    if (mode == 1) r.req_type = (p < 700) ? REQ_INSERT : (p < 990 ? REQ_SEARCH : REQ_NONE);
    else if (p < 480) r.req_type = REQ_SEARCH;
    else if (p < 960) r.req_type = REQ_INSERT;
    else if (p < 975) r.req_type = REQ_CLEAR;
    else r.req_type = REQ_NONE;
    return r;
  endfunction

  function automatic in_item_t mk(input req_t rq, input logic [47:0] key, input logic [7:0] m,
                                  input logic [95:0] w);
    in_item_t r;
    r.req_type = rq;
    {r.src_type, r.tgt_type, r.tgt_class} = key;
    r.kind_mask = m;
    {r.data_word0, r.data_word1, r.data_word2} = w;
    return r;
  endfunction

  task automatic send_item(input in_item_t item, input bit has_fixed, input out_item_t fixed);
    out_item_t exp;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp = lookup_rule(item);
    if (has_fixed && exp != fixed) begin
      mismatches++;
      if (mismatches <= 10) $display("directed row mismatch: table %h predictor %h", fixed, exp);
    end
    pending_results.push_back(exp);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver stall
  initial begin
    int wait_n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (2000) @(posedge clk);
        out_stall <= 1'b0;
        hold_long = 1'b0;
      end else if (out_valid && !out_stall) begin
        wait_n = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 10);
        if (wait_n != 0) begin
          out_stall <= 1'b1;
          repeat (wait_n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // result checking
  always @(posedge clk) begin
    out_item_t exp;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        exp = pending_results.pop_front();
        if (exp.status == ST_FULL) full_hits++;
        if (exp.status == ST_DUPLICATE) dup_hits++;
        if (exp.status == ST_OK && exp.found_kind != 0) found_hits++;
        if (out_data !== exp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d k=%h w=%h/%h/%h n=%0d got st=%0d k=%h w=%h/%h/%h n=%0d",
                     exp.status, exp.found_kind, exp.found_word0, exp.found_word1,
                     exp.found_word2, exp.entry_count, out_data.status, out_data.found_kind,
                     out_data.found_word0, out_data.found_word1, out_data.found_word2,
                     out_data.entry_count);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired");
      $display("access_rule_table_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    in_item_t rows [$];
    out_item_t row_exp [$];
    bit row_fixed [$];
    logic [47:0] ka, kb;
    out_item_t e;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_long = 1'b0;
    mismatches = 0;
    results_seen = 0;
    full_hits = 0;
    dup_hits = 0;
    found_hits = 0;
    idle_cycles = 0;
    rule_count = 0;
    for (int i = 0; i < 8; i++) key_pool[i] = 48'({$urandom, $urandom});
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    ka = '0;
    kb = '1;
    // directed rows: fixed expectations where obvious
    e = '0; e.status = ST_NOT_FOUND;
    rows.push_back(mk(REQ_SEARCH, ka, 8'hff, '0)); row_exp.push_back(e); row_fixed.push_back(1);
    e = '0; e.entry_count = 9'd1;
    rows.push_back(mk(REQ_INSERT, ka, 8'h01, '1)); row_exp.push_back(e); row_fixed.push_back(1);
    e = '0; e.status = ST_DUPLICATE; e.entry_count = 9'd1;
    rows.push_back(mk(REQ_INSERT, ka, 8'hff, '0)); row_exp.push_back(e); row_fixed.push_back(1);
    e = '0; e.entry_count = 9'd2;
    rows.push_back(mk(REQ_INSERT, ka, 8'h00, '0)); row_exp.push_back(e); row_fixed.push_back(1);
    e = '0; e.entry_count = 9'd3;
    rows.push_back(mk(REQ_INSERT, kb, 8'h80, {32'h0, 32'hffffffff, 32'h5a5a5a5a}));
    row_exp.push_back(e); row_fixed.push_back(1);
    e = '0; e.status = ST_NOT_FOUND; e.entry_count = 9'd3;
    rows.push_back(mk(REQ_SEARCH, ka, 8'h00, '0)); row_exp.push_back(e); row_fixed.push_back(1);
    e = '0; e.found_kind = 8'h01; e.found_word0 = '1; e.found_word1 = '1; e.found_word2 = '1;
    e.entry_count = 9'd3;
    rows.push_back(mk(REQ_SEARCH, ka, 8'hff, '0)); row_exp.push_back(e); row_fixed.push_back(1);
    rows.push_back(mk(REQ_SEARCH, kb, 8'hc0, '0)); row_exp.push_back('0); row_fixed.push_back(0);
    e = '0; e.entry_count = 9'd3;
    rows.push_back(mk(REQ_NONE, ka, 8'hff, '1)); row_exp.push_back(e); row_fixed.push_back(1);
    rows.push_back(mk(REQ_INSERT, kb, 8'h7f, '0)); row_exp.push_back('0); row_fixed.push_back(0);
    rows.push_back(mk(REQ_SEARCH, kb, 8'h02, '0)); row_exp.push_back('0); row_fixed.push_back(0);
    e = '0;
    rows.push_back(mk(REQ_CLEAR, kb, 8'hff, '1)); row_exp.push_back(e); row_fixed.push_back(1);
    e = '0; e.status = ST_NOT_FOUND;
    rows.push_back(mk(REQ_SEARCH, ka, 8'hff, '0)); row_exp.push_back(e); row_fixed.push_back(1);
    for (int i = 0; i < rows.size(); i++) send_item(rows[i], row_fixed[i], row_exp[i]);
    wait_drained();

    // fill to capacity, then duplicate-while-full and full
    for (int i = 0; i < Capacity; i++)
      send_item(mk(REQ_INSERT, {16'(i), 32'h1234_5678}, 8'h01, {$urandom, $urandom, $urandom}),
                0, '0);
    e = '0; e.status = ST_DUPLICATE; e.entry_count = 9'd256;
    send_item(mk(REQ_INSERT, {16'd0, 32'h1234_5678}, 8'hff, '0), 1, e);
    e = '0; e.status = ST_FULL; e.entry_count = 9'd256;
    send_item(mk(REQ_INSERT, kb, 8'h10, '0), 1, e);
    send_item(mk(REQ_SEARCH, {16'd255, 32'h1234_5678}, 8'h01, '0), 0, '0);

    // long receiver hold while sender keeps offering
    hold_long = 1'b1;
    for (int i = 0; i < 10; i++) send_item(rand_req(0), 0, '0);
    wait_drained();
    send_item(mk(REQ_CLEAR, ka, 8'h00, '0), 0, '0);

    for (int i = 0; i < 1450; i++) begin
      if (i % 300 == 150) wait_drained();
      send_item(rand_req(i >= 700 && i < 1000 ? 1 : 0), 0, '0);
    end

    wait_drained();
    repeat (Capacity + 20) @(posedge clk);
    $display("covered %0d results: %0d found, %0d duplicate, %0d full, with stalls on both sides",
             results_seen, found_hits, dup_hits, full_hits);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("access_rule_table_unit_tb: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("access_rule_table_unit_tb: errors");
    end
    $finish;
  end

endmodule
